[hw/rtl/dfsu_pkg.sv]
package dfsu_pkg;

   // graph size and derived widths
   localparam int NODES      = 16;
   localparam int ROW_W      = 16;
   localparam int NODE_W     = 4;
   localparam int ADJ_AW     = $clog2(NODES);
   localparam int STK_AW     = $clog2(NODES);
   localparam int SP_W       = 5;
   localparam int HIST_DEPTH = 32;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int LOG_W      = HIST_AW + 1;
   localparam int VC_W       = 5;
   localparam int SCAN_N     = (NODES < ROW_W) ? NODES : ROW_W;
   localparam int MODE_W     = 2;
   localparam int ACT_W      = 3;

   // item modes
   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FWD     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BACK    = 2'd3;

   // result actions
   localparam logic [ACT_W-1:0] ACT_PUSHED    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_POPPED    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FINISHED  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_UNDO_PUSH = 3'd3;
   localparam logic [ACT_W-1:0] ACT_UNDO_POP  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_NO_UNDO   = 3'd5;
   localparam logic [ACT_W-1:0] ACT_LOADED    = 3'd6;

   // log entry kinds
   localparam logic LOG_PUSH = 1'b0;
   localparam logic LOG_POP  = 1'b1;

   typedef struct packed {
      logic                adj_we;
      logic [ADJ_AW-1:0]   adj_waddr;
      logic [ROW_W-1:0]    adj_wdata;
      logic [ADJ_AW-1:0]   adj_raddr;
      logic                stk_we;
      logic [STK_AW-1:0]   stk_waddr;
      logic [NODE_W-1:0]   stk_wdata;
      logic [STK_AW-1:0]   stk_raddr;
      logic                hist_we;
      logic [HIST_AW-1:0]  hist_waddr;
      logic [NODE_W-1:0]   hist_wnode;
      logic                hist_wkind;
      logic [HIST_AW-1:0]  hist_raddr;
   } mem_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]    adj_row;
      logic [NODE_W-1:0]   stk_node;
      logic [NODE_W-1:0]   hist_node;
      logic                hist_kind;
   } mem_rsp_type;

   typedef struct packed {
      logic                clear;
      logic                inc;
      logic                dec;
      logic [NODE_W-1:0]   node;
   } vis_ctl_type;

   typedef struct packed {
      logic                found;
      logic [NODE_W-1:0]   node;
   } vis_scan_type;

endpackage

[hw/rtl/dfs_stepper_with_undo.sv]
// Depth-first search stepper with undo.
// Input channel req_*: one item per transfer, req_mode selects load row,
// restart, forward step or back step; req_row_index/req_row_bits carry a
// row for loads. Result channel rsp_*: exactly one result per item, in order.
// csr_wr_en/csr_wr_data write the start node; write only while idle.
// Loads, restarts and trivial steps go from idle straight to the output
// state; a forward push passes the scan state, a pop the scan and fix
// states, a back step the undo state and, when an undone push needs a
// fresh stack-top read, the fix state. Steps wait on registered reads of
// the adjacency, stack and history memories. The next item is taken once
// the result is loaded into the output register, so no new item is taken
// before the last is through. A stalled receiver holds the result register
// and the block waits in its output state until that register is free.
// Reset clears the stack pointer, log length, occurrence counts and start
// node; adjacency rows must be loaded before they are walked.
module dfs_stepper_with_undo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dfsu_pkg::MODE_W-1:0]   req_mode,
   input  logic [dfsu_pkg::NODE_W-1:0]   req_row_index,
   input  logic [dfsu_pkg::ROW_W-1:0]    req_row_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dfsu_pkg::ACT_W-1:0]    rsp_action,
   output logic [dfsu_pkg::NODE_W-1:0]   rsp_top_node,
   output logic                          rsp_top_valid,
   output logic [dfsu_pkg::SP_W-1:0]     rsp_stack_depth,
   output logic [dfsu_pkg::HIST_AW-1:0]  rsp_step_count,
   output logic                          rsp_finished,
   input  logic                          csr_wr_en,
   input  logic [dfsu_pkg::NODE_W-1:0]   csr_wr_data
);
   import dfsu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_UNDO = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [LOG_W-1:0]   log_ff, log_in;
   logic [NODE_W-1:0]  top_ff, top_in;
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [NODE_W-1:0]  start_ff;

   logic               rsp_valid_ff;
   logic [ACT_W-1:0]   rsp_action_ff;
   logic [NODE_W-1:0]  rsp_top_ff;
   logic               rsp_top_valid_ff;
   logic [SP_W-1:0]    rsp_depth_ff;
   logic [HIST_AW-1:0] rsp_count_ff;
   logic               rsp_finished_ff;

   mem_req_type        mreq;
   mem_rsp_type        mrsp;
   vis_ctl_type        vctl;
   vis_scan_type       vscan;

   logic               take;
   logic               out_free;
   logic               sp_room;
   logic               start_ok;

   dfsu_mems u_mems (
      .clock (clock),
      .req   (mreq),
      .rsp   (mrsp)
   );

   dfsu_visit u_visit (
      .clock (clock),
      .reset (reset),
      .ctl   (vctl),
      .row   (mrsp.adj_row),
      .scan  (vscan)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sp_room   = int'(sp_ff) < NODES;
   assign start_ok  = int'(start_ff) < NODES;

   // start node register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else if (csr_wr_en) begin
         start_ff <= csr_wr_data;
      end
   end

   // sequencer: decode, scan or undo, optional top refresh, result
   always_comb begin
      state_in = state_ff;
      sp_in    = sp_ff;
      log_in   = log_ff;
      top_in   = top_ff;
      act_in   = act_ff;
      vctl     = '0;
      vctl.node = top_ff;

      mreq            = '0;
      mreq.adj_waddr  = ADJ_AW'(req_row_index);
      mreq.adj_wdata  = req_row_bits;
      mreq.stk_waddr  = STK_AW'(sp_ff);
      mreq.stk_wdata  = start_ff;
      mreq.hist_waddr = HIST_AW'(log_ff);
      mreq.hist_wnode = top_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = S_OUT;
               act_in   = ACT_LOADED;
               unique case (req_mode)
                  MODE_LOAD: begin
                     mreq.adj_we = int'(req_row_index) < NODES;
                  end
                  MODE_RESTART: begin
                     vctl.clear     = 1'b1;
                     log_in         = '0;
                     sp_in          = start_ok ? SP_W'(1) : '0;
                     top_in         = start_ff;
                     mreq.stk_we    = start_ok;
                     mreq.stk_waddr = '0;
                  end
                  MODE_FWD: begin
                     if (sp_ff == '0) begin
                        if (log_ff == '0) begin
                           vctl.clear     = 1'b1;
                           sp_in          = start_ok ? SP_W'(1) : '0;
                           top_in         = start_ff;
                           mreq.stk_we    = start_ok;
                           mreq.stk_waddr = '0;
                        end else begin
                           act_in = ACT_FINISHED;
                        end
                     end else if (int'(log_ff) >= HIST_DEPTH) begin
                        act_in = ACT_FINISHED;
                     end else begin
                        // count the current top as visited before the scan
                        vctl.inc = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  MODE_BACK: begin
                     if (log_ff == '0) begin
                        act_in = ACT_NO_UNDO;
                     end else begin
                        state_in = S_UNDO;
                     end
                  end
                  default: begin
                     act_in = ACT_LOADED;
                  end
               endcase
            end
         end
         S_SCAN: begin
            mreq.hist_we = 1'b1;
            log_in       = log_ff + LOG_W'(1);
            if (vscan.found && sp_room) begin
               mreq.stk_we     = 1'b1;
               mreq.stk_wdata  = vscan.node;
               mreq.hist_wkind = LOG_PUSH;
               sp_in           = sp_ff + SP_W'(1);
               top_in          = vscan.node;
               act_in          = ACT_PUSHED;
               state_in        = S_OUT;
            end else begin
               mreq.hist_wkind = LOG_POP;
               sp_in           = sp_ff - SP_W'(1);
               act_in          = ACT_POPPED;
               state_in        = S_FIX;
            end
         end
         S_UNDO: begin
            vctl.dec  = 1'b1;
            vctl.node = mrsp.hist_node;
            log_in    = log_ff - LOG_W'(1);
            if (mrsp.hist_kind == LOG_PUSH) begin
               if (sp_ff != '0) begin
                  sp_in = sp_ff - SP_W'(1);
               end
               act_in   = ACT_UNDO_PUSH;
               state_in = S_FIX;
            end else begin
               if (sp_room) begin
                  mreq.stk_we    = 1'b1;
                  mreq.stk_wdata = mrsp.hist_node;
                  sp_in          = sp_ff + SP_W'(1);
                  top_in         = mrsp.hist_node;
               end
               act_in   = ACT_UNDO_POP;
               state_in = S_OUT;
            end
         end
         S_FIX: begin
            // stack read at the new top lands this cycle
            top_in   = mrsp.stk_node;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // read ports follow the top, the next stack top and the last log entry
      mreq.adj_raddr  = ADJ_AW'(top_ff);
      mreq.stk_raddr  = STK_AW'(sp_in - SP_W'(1));
      mreq.hist_raddr = HIST_AW'(log_ff - LOG_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         log_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         log_ff   <= log_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      act_ff <= act_in;
   end

   // result register: load on leaving the output state, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_action_ff    <= act_ff;
         rsp_top_ff       <= (sp_ff != '0) ? top_ff : '0;
         rsp_top_valid_ff <= (sp_ff != '0);
         rsp_depth_ff     <= sp_ff;
         rsp_count_ff     <= log_ff[HIST_AW-1:0];
         rsp_finished_ff  <= (sp_ff == '0) && (log_ff != '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_top_node    = rsp_top_ff;
   assign rsp_top_valid   = rsp_top_valid_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_step_count  = rsp_count_ff;
   assign rsp_finished    = rsp_finished_ff;

   // stack never grows past the node count
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      int'(sp_ff) <= NODES)
      else $error("stack pointer beyond node count");

   // history never holds more than its depth
   a_log_bound: assert property (@(posedge clock) disable iff (reset)
      int'(log_ff) <= HIST_DEPTH)
      else $error("log length beyond history depth");

   // an accepted item always leaves idle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   // a scan only follows an accepted forward step
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ($past(state_ff) == S_IDLE) && $past(take))
      else $error("scan entered without an accepted step");

   // a finished result never shows a live stack top
   a_finish_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_finished_ff && rsp_top_valid_ff))
      else $error("finished result with non-empty stack");

endmodule

[hw/rtl/dfsu_mems.sv]
module dfsu_mems (
   input  logic                 clock,
   input  dfsu_pkg::mem_req_type req,
   output dfsu_pkg::mem_rsp_type rsp
);
   import dfsu_pkg::*;

   logic [ROW_W-1:0]  adj_mem  [NODES];
   logic [NODE_W-1:0] stk_mem  [NODES];
   logic [NODE_W:0]   hist_mem [HIST_DEPTH];

   logic [ROW_W-1:0]  adj_rd_ff;
   logic [NODE_W-1:0] stk_rd_ff;
   logic [NODE_W:0]   hist_rd_ff;

   // adjacency rows: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req.adj_we) begin
         adj_mem[req.adj_waddr] <= req.adj_wdata;
      end
      adj_rd_ff <= adj_mem[req.adj_raddr];
   end

   // node stack
   always_ff @(posedge clock) begin
      if (req.stk_we) begin
         stk_mem[req.stk_waddr] <= req.stk_wdata;
      end
      stk_rd_ff <= stk_mem[req.stk_raddr];
   end

   // visited history with push/pop log bit alongside
   always_ff @(posedge clock) begin
      if (req.hist_we) begin
         hist_mem[req.hist_waddr] <= {req.hist_wkind, req.hist_wnode};
      end
      hist_rd_ff <= hist_mem[req.hist_raddr];
   end

   assign rsp.adj_row   = adj_rd_ff;
   assign rsp.stk_node  = stk_rd_ff;
   assign rsp.hist_node = hist_rd_ff[NODE_W-1:0];
   assign rsp.hist_kind = hist_rd_ff[NODE_W];

endmodule

[hw/rtl/dfsu_visit.sv]
module dfsu_visit (
   input  logic                   clock,
   input  logic                   reset,
   input  dfsu_pkg::vis_ctl_type  ctl,
   input  logic [dfsu_pkg::ROW_W-1:0] row,
   output dfsu_pkg::vis_scan_type scan
);
   import dfsu_pkg::*;

   logic [VC_W-1:0] cnt_ff [NODES];
   logic [VC_W-1:0] cnt_in [NODES];
   logic            node_ok;

   assign node_ok = int'(ctl.node) < NODES;

   // occurrence counts: clear on restart or a fresh start, bump on a forward step, drop on an undo
   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (ctl.clear) begin
            cnt_in[i] = '0;
         end else if (node_ok && (int'(ctl.node) == i)) begin
            if (ctl.inc) begin
               cnt_in[i] = cnt_ff[i] + VC_W'(1);
            end else if (ctl.dec && (cnt_ff[i] != '0)) begin
               cnt_in[i] = cnt_ff[i] - VC_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NODES; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // lowest-index neighbour with no occurrence in the history
   always_comb begin
      scan.found = 1'b0;
      scan.node  = '0;
      for (int j = SCAN_N - 1; j >= 0; j--) begin
         if (row[j] && (cnt_ff[j] == '0)) begin
            scan.found = 1'b1;
            scan.node  = NODE_W'(j);
         end
      end
   end

endmodule
